// ===== rtl/tkc_pkg.sv =====
// shared constants and types for the keyed lifetime cache
package tkc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int SIZE_W = 16;
  localparam int OBJ_W = 32;
  localparam int LIFE_W = 16;
  localparam int SLOT_W = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index 0: lifetime_frames
  localparam logic REG_LIFETIME = 1'b0;
  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(60);

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_AGE = 1'b1;

  typedef logic [SIZE_W-1:0] size_key_t;
  typedef logic [OBJ_W-1:0] obj_key_t;
  typedef logic [LIFE_W-1:0] life_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic action;
    size_key_t max_vert_count;
    obj_key_t object_id;
  } req_t;

  typedef struct packed {
    logic hit;
    logic [SLOT_W-1:0] slot;
    logic full_res;
  } rsp_t;

  // slot field carries the low bits of the entry index
  function automatic logic [SLOT_W-1:0] idx_to_slot(input idx_t idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/tkc_ifs.sv =====
// valid/ready stream interfaces for lookup requests and results
interface tkc_in_if import tkc_pkg::*; ();
  logic valid;
  logic ready;
  logic action;
  size_key_t max_vert_count;
  obj_key_t object_id;

  modport source (output valid, action, max_vert_count, object_id, input ready);
  modport sink (input valid, action, max_vert_count, object_id, output ready);
endinterface

interface tkc_out_if import tkc_pkg::*; ();
  logic valid;
  logic ready;
  logic hit;
  logic [SLOT_W-1:0] slot;
  logic full_res;

  modport source (output valid, hit, slot, full_res, input ready);
  modport sink (input valid, hit, slot, full_res, output ready);
endinterface

// ===== rtl/ttl_keyed_result_cache.sv =====
// keyed lifetime cache: fully associative slots with per-entry frame countdown
//
// in_beat carries one item: action 0 looks up (max_vert_count, object_id),
// action 1 marks a frame end. every item yields exactly one beat on out_beat.
// a hit reloads the entry lifetime and returns its slot with hit set; a miss
// claims the lowest free slot with a full lifetime; a miss with every slot
// taken returns full_res and stores nothing. frame end ages all entries and
// frees those that reach zero, returning all-zero fields.
// an input beat first sits in the input register; then the parallel key
// compare over all slots and the slot update happen in one pass into the
// result register. throughput is one item per cycle unless the receiver
// stalls; the slot table is updated at the edge the result is registered,
// so the next item already sees it.
// when the receiver stalls the result register holds and the input register
// keeps one more item, after which in_beat.ready drops.
// lifetime_frames sits at byte address 0 of the cfg_ APB port, reset 60.
// reset (rst_n low, synchronous) frees every slot and empties both registers.
module ttl_keyed_result_cache import tkc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tkc_in_if.sink                in_beat,
  tkc_out_if.source             out_beat,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  life_t lifetime_r;

  logic req_v_r;
  req_t req_r;
  logic out_v_r;
  rsp_t rsp_r;

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  size_key_t size_key_r [ENTRIES];
  obj_key_t obj_key_r [ENTRIES];
  life_t life_r [ENTRIES];

  logic [ENTRIES-1:0] match;
  logic found;
  logic free_any;
  idx_t found_idx;
  idx_t free_idx;
  rsp_t rsp_nxt;
  logic proc;
  logic do_age;
  logic do_write;
  idx_t wr_idx;
  logic wr_new;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_LIFETIME) ?
                      CFG_DATA_W'(lifetime_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CFG_ADDR_W-1] == REG_LIFETIME) begin
      lifetime_r <= cfg_pwdata[LIFE_W-1:0];
    end
  end

  // handshake
  assign proc = req_v_r && (!out_v_r || out_beat.ready);
  assign in_beat.ready = !req_v_r || proc;

  // parallel compare and lowest-index search
  always_comb begin
    found = 1'b0;
    free_any = 1'b0;
    found_idx = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && size_key_r[i] == req_r.max_vert_count &&
                 obj_key_r[i] == req_r.object_id;
      if (match[i]) begin
        found = 1'b1;
        found_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    do_age = proc && req_r.action == ACT_AGE;
    do_write = proc && req_r.action == ACT_LOOKUP && (found || free_any);
    wr_new = !found;
    wr_idx = found ? found_idx : free_idx;
    rsp_nxt = '0;
    if (req_r.action == ACT_LOOKUP) begin
      if (found) begin
        rsp_nxt.hit = 1'b1;
        rsp_nxt.slot = idx_to_slot(found_idx);
      end else if (free_any) begin
        rsp_nxt.slot = idx_to_slot(free_idx);
      end else begin
        rsp_nxt.full_res = 1'b1;
      end
    end
  end

  // an aged entry survives only while its lifetime stays above zero
  always_comb begin
    valid_nxt = valid_r;
    if (do_age) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_nxt[i] = valid_r[i] && life_r[i] > LIFE_W'(1);
      end
    end else if (do_write && wr_new) begin
      valid_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_age) begin
        if (valid_r[i] && life_r[i] != '0) begin
          life_r[i] <= life_r[i] - LIFE_W'(1);
        end
      end else if (do_write && wr_idx == IDX_W'(i)) begin
        life_r[i] <= lifetime_r;
        if (wr_new) begin
          size_key_r[i] <= req_r.max_vert_count;
          obj_key_r[i] <= req_r.object_id;
        end
      end
    end
  end

  // input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_beat.ready) begin
        req_v_r <= in_beat.valid;
      end
      if (proc) begin
        out_v_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.valid && in_beat.ready) begin
      req_r.action <= in_beat.action;
      req_r.max_vert_count <= in_beat.max_vert_count;
      req_r.object_id <= in_beat.object_id;
    end
    if (proc) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_beat.valid = out_v_r;
  assign out_beat.hit = rsp_r.hit;
  assign out_beat.slot = rsp_r.slot;
  assign out_beat.full_res = rsp_r.full_res;

`ifndef SYNTHESIS
  // a lookup that did not report full leaves its slot valid
  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> valid_r[$past(wr_idx)])
    else $error("written slot not valid");

  // full is reported only when every slot was taken and nothing matched
  a_full_only_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
    proc && rsp_nxt.full_res |-> (&valid_r) && !found)
    else $error("full reported with a free or matching slot");

  // frame end gives an all-zero result beat
  a_age_result: assert property (@(posedge clk) disable iff (!rst_n)
    do_age |=> out_v_r && !rsp_r.hit && !rsp_r.full_res && rsp_r.slot == '0)
    else $error("frame end result not zero");

  // a key is never held in two slots
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    req_v_r && req_r.action == ACT_LOOKUP |-> $onehot0(match))
    else $error("key stored in more than one slot");

  // input stalls only behind a held item
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_beat.ready |-> req_v_r && out_v_r && !out_beat.ready)
    else $error("input stalled without cause");
`endif

endmodule
